// ===== design/dlr_pkg.sv =====
package dlr_pkg;

  localparam int COORD_WIDTH_DEF = 12;
  localparam int DASH_WIDTH_DEF  = 8;

  // depth of the queue between front and back
  localparam int MID_DEPTH = 2;

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // configuration register indexes
  localparam logic CFG_DASH_ON  = 1'b0;
  localparam logic CFG_DASH_OFF = 1'b1;

  typedef struct packed {
    logic kind;
    logic steep;
    logic x_neg;
    logic y_neg;
  } line_flags_t;

endpackage

// ===== design/dlr_fifo.sv =====
module dlr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== design/dlr_front.sv =====
module dlr_front #(
  parameter int COORD_WIDTH = dlr_pkg::COORD_WIDTH_DEF
) (
  input  logic                    kind,
  input  logic [COORD_WIDTH-1:0]  start_x,
  input  logic [COORD_WIDTH-1:0]  start_y,
  input  logic [COORD_WIDTH-1:0]  end_x,
  input  logic [COORD_WIDTH-1:0]  end_y,
  output dlr_pkg::line_flags_t    flags,
  output logic [COORD_WIDTH-1:0]  major,
  output logic [COORD_WIDTH-1:0]  minor,
  output logic [COORD_WIDTH+2:0]  err_init
);
  import dlr_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic signed [CW:0] dx;
  logic signed [CW:0] dy;
  logic [CW:0]        dx_abs;
  logic [CW:0]        dy_abs;
  logic [CW-1:0]      adx;
  logic [CW-1:0]      ady;
  logic               steep;

  always_comb begin
    dx     = $signed({end_x[CW-1], end_x}) - $signed({start_x[CW-1], start_x});
    dy     = $signed({end_y[CW-1], end_y}) - $signed({start_y[CW-1], start_y});
    dx_abs = dx[CW] ? -dx : dx;
    dy_abs = dy[CW] ? -dy : dy;
    adx    = dx_abs[CW-1:0];
    ady    = dy_abs[CW-1:0];
    steep  = ady > adx;

    major    = steep ? ady : adx;
    minor    = steep ? adx : ady;
    // 2*minor - major
    err_init = {2'b00, minor, 1'b0} - {3'b000, major};

    flags.kind  = kind;
    flags.steep = steep;
    flags.x_neg = dx[CW];
    flags.y_neg = dy[CW];
  end

endmodule

// ===== design/dlr_back.sv =====
module dlr_back #(
  parameter int COORD_WIDTH = dlr_pkg::COORD_WIDTH_DEF,
  parameter int DASH_WIDTH  = dlr_pkg::DASH_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  dlr_pkg::line_flags_t    flags,
  input  logic [COORD_WIDTH-1:0]  start_x,
  input  logic [COORD_WIDTH-1:0]  start_y,
  input  logic [COORD_WIDTH-1:0]  major,
  input  logic [COORD_WIDTH-1:0]  minor,
  input  logic [COORD_WIDTH+2:0]  err_init,
  input  logic [DASH_WIDTH-1:0]   dash_on,
  input  logic [DASH_WIDTH-1:0]   dash_off,
  output logic                    item_take,
  input  logic                    pop,
  output logic                    empty,
  output logic [COORD_WIDTH-1:0]  pixel_x,
  output logic [COORD_WIDTH-1:0]  pixel_y,
  output logic                    paint,
  output logic                    last_pixel
);
  import dlr_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = DASH_WIDTH;

  // walk state
  logic          active, active_next;
  logic [CW-1:0] cur_x, cur_x_next;
  logic [CW-1:0] cur_y, cur_y_next;
  logic [CW+2:0] err, err_next;
  logic [CW-1:0] major_d, major_d_next;
  logic [CW-1:0] minor_d, minor_d_next;
  logic [CW-1:0] steps_left, steps_left_next;
  logic [DW:0]   dash_count, dash_count_next;
  logic          steep, steep_next;
  logic          x_neg, x_neg_next;
  logic          y_neg, y_neg_next;

  logic          out_valid;
  logic          out_free;
  logic          out_load;
  logic          out_last;

  logic [CW-1:0] x_unit;
  logic [CW-1:0] y_unit;
  logic [CW+2:0] two_minor;
  logic [CW+2:0] two_major;
  logic          err_pos;
  logic [DW:0]   dash_inc;
  logic [DW:0]   dash_period;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign item_take = item_valid && out_free;

  always_comb begin
    active_next     = active;
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    err_next        = err;
    major_d_next    = major_d;
    minor_d_next    = minor_d;
    steps_left_next = steps_left;
    dash_count_next = dash_count;
    steep_next      = steep;
    x_neg_next      = x_neg;
    y_neg_next      = y_neg;
    out_load        = 1'b0;
    out_last        = 1'b0;

    x_unit      = {{(CW-1){x_neg}}, 1'b1};
    y_unit      = {{(CW-1){y_neg}}, 1'b1};
    two_minor   = {2'b00, minor_d, 1'b0};
    two_major   = {2'b00, major_d, 1'b0};
    err_pos     = !err[CW+2] && (err != '0);
    dash_inc    = dash_count + 1'b1;
    dash_period = {1'b0, dash_on} + {1'b0, dash_off};

    if (item_take) begin
      if (flags.kind == KIND_START) begin
        cur_x_next      = start_x;
        cur_y_next      = start_y;
        err_next        = err_init;
        major_d_next    = major;
        minor_d_next    = minor;
        steps_left_next = major;
        dash_count_next = '0;
        steep_next      = flags.steep;
        x_neg_next      = flags.x_neg;
        y_neg_next      = flags.y_neg;
        active_next     = (major != '0);
        out_load        = 1'b1;
        out_last        = (major == '0);
      end else if (active) begin
        if (err_pos) begin
          if (steep) begin
            cur_x_next = cur_x + x_unit;
          end else begin
            cur_y_next = cur_y + y_unit;
          end
          err_next = err + two_minor - two_major;
        end else begin
          err_next = err + two_minor;
        end
        if (steep) begin
          cur_y_next = cur_y + y_unit;
        end else begin
          cur_x_next = cur_x + x_unit;
        end
        steps_left_next = steps_left - 1'b1;
        dash_count_next = (dash_inc >= dash_period) ? '0 : dash_inc;
        out_load        = 1'b1;
        out_last        = (steps_left_next == '0);
        if (out_last) begin
          active_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      active <= active_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_x      <= cur_x_next;
    cur_y      <= cur_y_next;
    err        <= err_next;
    major_d    <= major_d_next;
    minor_d    <= minor_d_next;
    steps_left <= steps_left_next;
    dash_count <= dash_count_next;
    steep      <= steep_next;
    x_neg      <= x_neg_next;
    y_neg      <= y_neg_next;
    if (out_load) begin
      pixel_x    <= cur_x_next;
      pixel_y    <= cur_y_next;
      paint      <= (dash_count_next < {1'b0, dash_on});
      last_pixel <= out_last;
    end
  end

endmodule

// ===== design/dashed_line_rasterizer_core.sv =====
// Dashed line rasteriser core.
// Input queue side: push/full. A beat is taken when push is high and full is low.
//   kind start loads the endpoints and gives the start pixel; kind step gives the
//   next pixel along the major axis. A step with no line running gives nothing.
// Result queue side: empty/pop. While empty is low the oldest pixel is on
//   pixel_x/pixel_y/paint/last_pixel; it leaves when pop is high.
// Config: cfg_write with cfg_index 0 sets the dash on length, 1 the dash off
//   length. Only write while no beats are in flight.
// The edge that takes a beat writes it into the middle queue; the walker then
//   takes it once the result register is free and loads the pixel there, where
//   it waits until it is popped.
// Throughput: one beat per cycle while pop stays high; the walker does one
//   Bresenham step (one add and compare on the error term) per cycle.
// A two-beat queue sits between the setup front and the walker, so a stalled
//   receiver first fills the result register, then the queue, then full rises.
//   Input and output are registered apart, so a beat is still taken while a
//   result waits.
// Reset: no line running, queues empty, dash on length 1, off length 0.
module dashed_line_rasterizer_core #(
  parameter int COORD_WIDTH = dlr_pkg::COORD_WIDTH_DEF,
  parameter int DASH_WIDTH  = dlr_pkg::DASH_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic                   kind,
  input  logic [COORD_WIDTH-1:0] start_x,
  input  logic [COORD_WIDTH-1:0] start_y,
  input  logic [COORD_WIDTH-1:0] end_x,
  input  logic [COORD_WIDTH-1:0] end_y,
  output logic                   empty,
  input  logic                   pop,
  output logic [COORD_WIDTH-1:0] pixel_x,
  output logic [COORD_WIDTH-1:0] pixel_y,
  output logic                   paint,
  output logic                   last_pixel,
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [DASH_WIDTH-1:0]  cfg_data
);
  import dlr_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int FLAG_W = $bits(line_flags_t);
  localparam int ITEM_W = FLAG_W + 4 * CW + CW + 3;

  // dash pattern registers
  logic [DASH_WIDTH-1:0] dash_on_length;
  logic [DASH_WIDTH-1:0] dash_off_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_on_length  <= DASH_WIDTH'(1);
      dash_off_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DASH_ON:  dash_on_length  <= cfg_data;
        CFG_DASH_OFF: dash_off_length <= cfg_data;
        default:      dash_on_length  <= dash_on_length;
      endcase
    end
  end

  // front: octant setup on the incoming beat
  line_flags_t   fr_flags;
  logic [CW-1:0] fr_major;
  logic [CW-1:0] fr_minor;
  logic [CW+2:0] fr_err;

  dlr_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .kind     (kind),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .flags    (fr_flags),
    .major    (fr_major),
    .minor    (fr_minor),
    .err_init (fr_err)
  );

  // queue between setup and walker
  logic [ITEM_W-1:0] mid_wdata;
  logic [ITEM_W-1:0] mid_rdata;
  logic              mid_full;
  logic              mid_empty;
  logic              mid_pop;

  assign mid_wdata = {fr_flags, start_x, start_y, fr_major, fr_minor, fr_err};
  assign full      = mid_full;

  dlr_fifo #(
    .WIDTH(ITEM_W),
    .DEPTH(MID_DEPTH)
  ) u_mid (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .full  (mid_full),
    .empty (mid_empty)
  );

  line_flags_t   bk_flags;
  logic [CW-1:0] bk_sx;
  logic [CW-1:0] bk_sy;
  logic [CW-1:0] bk_major;
  logic [CW-1:0] bk_minor;
  logic [CW+2:0] bk_err;

  assign {bk_flags, bk_sx, bk_sy, bk_major, bk_minor, bk_err} = mid_rdata;

  // back: Bresenham walker, dash counter and result register
  dlr_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .DASH_WIDTH (DASH_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!mid_empty),
    .flags      (bk_flags),
    .start_x    (bk_sx),
    .start_y    (bk_sy),
    .major      (bk_major),
    .minor      (bk_minor),
    .err_init   (bk_err),
    .dash_on    (dash_on_length),
    .dash_off   (dash_off_length),
    .item_take  (mid_pop),
    .pop        (pop),
    .empty      (empty),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .paint      (paint),
    .last_pixel (last_pixel)
  );

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // walker only takes a beat when the result register can be loaded
  a_take_space: assert property (@(posedge clk) disable iff (rst)
    mid_pop |-> (empty || pop))
    else $error("beat taken with result register occupied");

  // full means the middle queue holds beats for the walker
  a_full_has_data: assert property (@(posedge clk) disable iff (rst)
    full |-> !mid_empty)
    else $error("full with empty middle queue");

endmodule

// ===== dv/dashed_line_rasterizer_core_tb.sv =====
`timescale 1ns / 100ps

module dashed_line_rasterizer_core_tb;
  import dlr_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int DW = DASH_WIDTH_DEF;

  // Generous: ~750 beats, each slowed at worst by both sides idling.
  localparam int CYCLE_LIMIT      = 400000;
  localparam int PHASES           = 8;
  localparam int PIXELS_PER_PHASE = 72;
  localparam int COORD_MIN        = -(1 << (CW - 1));
  localparam int COORD_MAX        = (1 << (CW - 1)) - 1;

  // how the expectation of a beat is formed
  typedef enum logic [1:0] {
    ROW_PREDICT, // worked out by the line walker below
    ROW_PIXEL,   // pixel typed into the table
    ROW_SILENT   // typed: the beat must give no pixel
  } row_mode_t;

  typedef struct packed {
    logic                 kind;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
  } beat_t;

  localparam int BEAT_W = $bits(beat_t);

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 paint;
    logic                 is_end;
  } pixel_t;

  typedef struct {
    beat_t     beat;
    row_mode_t mode;
    pixel_t    pin;
  } row_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic          clk;
  logic          rst       = 1'b1;
  logic          push      = 1'b0;
  logic          full;
  logic          kind      = KIND_START;
  logic [CW-1:0] start_x   = '0;
  logic [CW-1:0] start_y   = '0;
  logic [CW-1:0] end_x     = '0;
  logic [CW-1:0] end_y     = '0;
  logic          empty;
  logic          pop       = 1'b0;
  logic [CW-1:0] pixel_x;
  logic [CW-1:0] pixel_y;
  logic          paint;
  logic          last_pixel;
  logic          cfg_write = 1'b0;
  logic          cfg_index = CFG_DASH_ON;
  logic [DW-1:0] cfg_data  = '0;

  // sideband travelling with each input beat: how its pixel is expected
  row_mode_t pin_mode  = ROW_PREDICT;
  pixel_t    pin_pixel = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  dashed_line_rasterizer_core #(
    .COORD_WIDTH (CW),
    .DASH_WIDTH  (DW)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .empty      (empty),
    .pop        (pop),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .paint      (paint),
    .last_pixel (last_pixel),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Line walker: our own copy of the dash registers and the Bresenham state
  // ---------------------------------------------------------------------------
  logic [DW-1:0] dash_on_len  = DW'(1);
  logic [DW-1:0] dash_off_len = '0;

  bit ln_active, ln_steep, ln_xneg, ln_yneg;
  int ln_x, ln_y, ln_err, ln_major, ln_minor, ln_left, ln_dash;

  pixel_t pixel_q[$];     // pixels still owed by the DUT, oldest first
  row_t   dir_rows[$];    // directed stimulus table
  int     pixels_due;     // beats so far that owe a pixel
  int     errors;
  int     cycle_count;
  int     send_idle_pct;
  int     recv_stall_pct;

  // One beat through the walker. A start loads the endpoints and gives the
  // first pixel; a step moves one pixel along the major axis, or gives nothing
  // once the line has run out.
  task automatic walk_line(input beat_t b, output bit produced, output pixel_t px);
    int sxv, syv, dx, dy, xs, ys;
    produced = 1'b0;
    px       = '0;
    if (b.kind == KIND_START) begin
      sxv       = $signed(b.sx);
      syv       = $signed(b.sy);
      dx        = $signed(b.ex);
      dy        = $signed(b.ey);
      dx        = dx - sxv;
      dy        = dy - syv;
      ln_xneg   = dx < 0;
      ln_yneg   = dy < 0;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      ln_steep  = dy > dx;
      ln_major  = ln_steep ? dy : dx;
      ln_minor  = ln_steep ? dx : dy;
      ln_err    = 2 * ln_minor - ln_major;
      ln_left   = ln_major;
      ln_x      = sxv;
      ln_y      = syv;
      ln_dash   = 0;
      ln_active = ln_left != 0;
      produced  = 1'b1;
    end else if (ln_active) begin
      xs = ln_xneg ? -1 : 1;
      ys = ln_yneg ? -1 : 1;
      // minor axis moves only while the error term is positive
      if (ln_err > 0) begin
        if (ln_steep) ln_x += xs;
        else ln_y += ys;
        ln_err += 2 * ln_minor - 2 * ln_major;
      end else begin
        ln_err += 2 * ln_minor;
      end
      if (ln_steep) ln_y += ys;
      else ln_x += xs;
      ln_left--;
      // dash position wraps at the period; registers are read live, so a
      // count left over from a longer period wraps here as well
      ln_dash++;
      if (ln_dash >= int'(dash_on_len) + int'(dash_off_len)) ln_dash = 0;
      if (ln_left <= 0) begin
        ln_left   = 0;
        ln_active = 1'b0;
      end
      produced = 1'b1;
    end
    if (produced) begin
      px.x      = ln_x[CW-1:0];
      px.y      = ln_y[CW-1:0];
      px.paint  = ln_dash < int'(dash_on_len);
      px.is_end = !ln_active;
    end
  endtask

  task automatic flag_mismatch(input string msg);
    errors++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: pixels leaving first, then the beat entering at the same edge.
  // Both are judged on pre-edge values, so ordering within the step is moot.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    pixel_t got, want, px;
    beat_t  b;
    bit     produced;
    if (!rst) begin
      if (pop && !empty) begin
        got = '{x: pixel_x, y: pixel_y, paint: paint, is_end: last_pixel};
        if (pixel_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected pixel (%0d,%0d)", got.x, got.y));
        end else begin
          want = pixel_q.pop_front();
          if (got.x !== want.x)
            flag_mismatch($sformatf("pixel_x %0d, want %0d", got.x, want.x));
          if (got.y !== want.y)
            flag_mismatch($sformatf("pixel_y %0d, want %0d", got.y, want.y));
          if (got.paint !== want.paint)
            flag_mismatch($sformatf("paint %0b, want %0b at (%0d,%0d)",
                                    got.paint, want.paint, want.x, want.y));
          if (got.is_end !== want.is_end)
            flag_mismatch($sformatf("last_pixel %0b, want %0b at (%0d,%0d)",
                                    got.is_end, want.is_end, want.x, want.y));
        end
      end
      if (push && !full) begin
        b = '{kind: kind, sx: start_x, sy: start_y, ex: end_x, ey: end_y};
        walk_line(b, produced, px);
        // typed rows override the walker, whose state still moves on
        case (pin_mode)
          ROW_PIXEL: begin
            pixel_q.push_back(pin_pixel);
            pixels_due++;
          end
          ROW_SILENT: ;
          default: begin
            if (produced) begin
              pixel_q.push_back(px);
              pixels_due++;
            end
          end
        endcase
      end
    end
  end

  // receiver: pop dropped at random per cycle
  always @(posedge clk) pop <= !rst && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Present one beat, idling first at random, and hold it until it is taken.
  // push stays high on exit so back-to-back beats need no second assignment.
  task automatic send_beat(input beat_t b, input row_mode_t mode, input pixel_t pin);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    kind      <= b.kind;
    start_x   <= b.sx;
    start_y   <= b.sy;
    end_x     <= b.ex;
    end_y     <= b.ey;
    pin_mode  <= mode;
    pin_pixel <= pin;
    do @(posedge clk); while (full);
  endtask

  // Stop sending and wait for every owed pixel, then wait on so that a step on a
  // finished line, which gives nothing but may still be in flight, is through.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dash(input int on_len, input int off_len);
    cfg_write <= 1'b1;
    cfg_index <= CFG_DASH_ON;
    cfg_data  <= on_len[DW-1:0];
    @(posedge clk);
    dash_on_len = on_len[DW-1:0];
    cfg_index <= CFG_DASH_OFF;
    cfg_data  <= off_len[DW-1:0];
    @(posedge clk);
    dash_off_len = off_len[DW-1:0];
    cfg_write <= 1'b0;
  endtask

  task automatic add_row(input logic k, input int sx, input int sy, input int ex,
                         input int ey, input row_mode_t mode, input int px = 0,
                         input int py = 0, input logic pnt = 1'b0,
                         input logic lst = 1'b0);
    row_t r;
    r.beat.kind  = k;
    r.beat.sx    = sx[CW-1:0];
    r.beat.sy    = sy[CW-1:0];
    r.beat.ex    = ex[CW-1:0];
    r.beat.ey    = ey[CW-1:0];
    r.mode       = mode;
    r.pin.x      = px[CW-1:0];
    r.pin.y      = py[CW-1:0];
    r.pin.paint  = pnt;
    r.pin.is_end = lst;
    dir_rows.push_back(r);
  endtask

  function automatic int rand_coord();
    logic [CW-1:0] r;
    r = CW'($urandom);
    return int'($signed(r));
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // One random line: a start, then a run of steps. Mostly short lines anywhere
  // on the plane, walked to the end and a little past; some are cut short by
  // the next start, a few are long and only partly walked, and now and then
  // stray steps come first.
  task automatic line_burst();
    beat_t       b;
    int          sx, sy, ex, ey, span, len, adx, ady, n;
    int unsigned pick;
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        b      = BEAT_W'({$urandom, $urandom});
        b.kind = KIND_STEP;
        send_beat(b, ROW_PREDICT, '0);
      end
    end
    sx   = rand_coord();
    sy   = rand_coord();
    pick = $urandom_range(11);
    if (pick == 0) begin
      ex = rand_coord();
      ey = rand_coord();
    end else begin
      span = (pick < 3) ? 40 : 9;
      ex   = clamp_coord(sx + $urandom_range(2 * span) - span);
      ey   = clamp_coord(sy + $urandom_range(2 * span) - span);
    end
    b = '{kind: KIND_START, sx: sx[CW-1:0], sy: sy[CW-1:0],
          ex: ex[CW-1:0], ey: ey[CW-1:0]};
    send_beat(b, ROW_PREDICT, '0);
    adx = (ex > sx) ? ex - sx : sx - ex;
    ady = (ey > sy) ? ey - sy : sy - ey;
    len = (adx > ady) ? adx : ady;
    if (len > 30) len = 30;
    n = ($urandom_range(3) == 0) ? $urandom_range(len) : len + $urandom_range(2);
    repeat (n) begin
      b      = BEAT_W'({$urandom, $urandom}); // step coordinates are ignored: let them toggle
      b.kind = KIND_STEP;
      send_beat(b, ROW_PREDICT, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  int phase_on  [PHASES] = '{1, 3, 0, 255, 0, 255, 0, 0};
  int phase_off [PHASES] = '{0, 2, 0, 255, 255, 0, 0, 0};

  initial begin
    int p, goal, on_len, off_len;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table, reset dash settings (on 1, off 0): every pixel painted.
    // step before any line: nothing
    add_row(KIND_STEP, 0, 0, 0, 0, ROW_SILENT);
    // start equal to end: single pixel, flagged last, line closed
    add_row(KIND_START, 0, 0, 0, 0, ROW_PIXEL, 0, 0, 1'b1, 1'b1);
    add_row(KIND_STEP, 0, 0, 0, 0, ROW_SILENT);
    // horizontal, +x, from the corner of the plane
    add_row(KIND_START, -2048, 2047, -2045, 2047, ROW_PIXEL, -2048, 2047, 1'b1, 1'b0);
    repeat (3) add_row(KIND_STEP, 2047, -2048, 2047, -2048, ROW_PREDICT);
    // past the end point: nothing
    add_row(KIND_STEP, -1, -1, -1, -1, ROW_SILENT);
    // vertical, +y, opposite corner; dropped after one step
    add_row(KIND_START, 2047, -2048, 2047, -2044, ROW_PIXEL, 2047, -2048, 1'b1, 1'b0);
    add_row(KIND_STEP, 0, 0, 0, 0, ROW_PREDICT);
    // steep, both axes negative: exactly the major length of steps
    add_row(KIND_START, 5, 5, 3, 0, ROW_PIXEL, 5, 5, 1'b1, 1'b0);
    repeat (5) add_row(KIND_STEP, 0, 0, 0, 0, ROW_PREDICT);
    // full diagonal across the plane, left running for a while
    add_row(KIND_START, 2047, 2047, -2048, -2048, ROW_PIXEL, 2047, 2047, 1'b1, 1'b0);
    add_row(KIND_STEP, 0, 0, 0, 0, ROW_PREDICT);
    // shallow, -x +y, restarting over the running line
    add_row(KIND_START, -1, -1, -4, 1, ROW_PIXEL, -1, -1, 1'b1, 1'b0);
    repeat (3) add_row(KIND_STEP, 0, 0, 0, 0, ROW_PREDICT);
    // 45 degrees, +x -y
    add_row(KIND_START, 0, 0, 2, -2, ROW_PIXEL, 0, 0, 1'b1, 1'b0);
    repeat (2) add_row(KIND_STEP, 0, 0, 0, 0, ROW_PREDICT);

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].mode, dir_rows[i].pin);

    // Random phases: dash settings and idling change only with the DUT drained.
    // Idle modes cycle: none, sender 79%, receiver 79%, both 16%.
    goal = 0;
    for (p = 0; p < PHASES; p++) begin
      settle();
      on_len  = phase_on[p];
      off_len = phase_off[p];
      if (p >= 6) begin
        on_len  = $urandom_range(1, 6);
        off_len = $urandom_range(0, 5);
      end
      write_dash(on_len, off_len);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      goal += PIXELS_PER_PHASE;
      while (pixels_due < goal - PIXELS_PER_PHASE / 2) line_burst();
      // hold off mid-phase until the DUT has handed back everything
      settle();
      while (pixels_due < goal) line_burst();
    end

    settle();
    repeat (8) @(posedge clk);
    if (pixel_q.size() != 0)
      flag_mismatch($sformatf("%0d pixels never came out", pixel_q.size()));
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
